/* rtl/acrp_pkg.sv */
// Shared types, codes and constants for the account credit refill policer.
`timescale 1ns / 1ps
`default_nettype none

package acrp_pkg;

  // Default table depth and the balance every account holds after reset
  localparam int unsigned NUM_ACCOUNTS_DEF = 256;
  localparam logic [31:0] INIT_BALANCE     = 32'd10000;
  localparam logic [30:0] INIT_CAP         = 31'd10000;

  // Field widths fixed by the command format
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned AMOUNT_W  = 16;
  localparam int unsigned ACCOUNT_W = 8;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned BAL_W     = 32;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CAP_W     = 31;
  localparam int unsigned EFFECT_W  = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 31;
  localparam int unsigned PROD_W    = TICK_W + AMOUNT_W;
  // Shared adder width: balance plus full product, with sign headroom
  localparam int unsigned ALU_W     = PROD_W + 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  // Effect modes, bits 17:16 of an effect register
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT  = 3'd5;

  // Action indexes with an effect register of their own
  localparam logic [ACTION_W-1:0] ACT_0 = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_1 = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_2 = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_3 = 3'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_ELAPSED,
    ST_MUL,
    ST_REFILL,
    ST_CAP,
    ST_EFFECT,
    ST_COMMIT
  } state_e;

endpackage

`default_nettype wire

/* rtl/acrp_table.sv */
// Single-port account table: one write or one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module acrp_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

/* rtl/account_credit_refill_policer.sv */
// Top level of the account credit refill policer: sequencer, shared adder, table.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+------------------------------------
// command  | in        | start & !busy                 | command_i tick_amount_i account_i
//          |           |                               | action_i force_req_i
// result   | out       | result_valid_o (one cycle)    | ok_o balance_o
// config   | in        | cfg_valid_i & cfg_ready_o     | cfg_index_i cfg_data_i
//
// Sequence: a tick or an unused command is done in idle; its result strobes in the next cycle.
// A perform or check makes one pass of the shared adder per index reduction step,
// then steps through read, elapsed, multiply, refill, cap, effect and commit, with
// the result strobed the cycle after commit; the single table port and the one
// shared adder keep these steps in series, and busy stays high until commit.
// Reset: a clearing pass loads every account with balance 10000 and timestamp
// zero; busy stays high until it ends. Config writes are taken at all times. The
// receiver cannot stall: each result is shown for exactly one cycle.

module account_credit_refill_policer #(
  parameter int unsigned NUM_ACCOUNTS = acrp_pkg::NUM_ACCOUNTS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [acrp_pkg::CMD_W-1:0]           command_i,
  input  wire logic [acrp_pkg::AMOUNT_W-1:0]        tick_amount_i,
  input  wire logic [acrp_pkg::ACCOUNT_W-1:0]       account_i,
  input  wire logic [acrp_pkg::ACTION_W-1:0]        action_i,
  input  wire logic                                 force_req_i,
  // result channel
  output logic                                      result_valid_o,
  output logic                                      ok_o,
  output logic signed [acrp_pkg::BAL_W-1:0]         balance_o,
  // configuration channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [acrp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [acrp_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  // Table address width, and the width of the index while it is reduced
  localparam int unsigned AW     = (NUM_ACCOUNTS > 1) ? $clog2(NUM_ACCOUNTS) : 1;
  localparam int unsigned IW     = (AW > acrp_pkg::ACCOUNT_W) ? AW : acrp_pkg::ACCOUNT_W;
  localparam int unsigned ALU_W  = acrp_pkg::ALU_W;
  localparam int unsigned BAL_W  = acrp_pkg::BAL_W;
  localparam int unsigned TICK_W = acrp_pkg::TICK_W;
  localparam int unsigned WORD_W = TICK_W + BAL_W;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(NUM_ACCOUNTS - 1);

  localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
  localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

  acrp_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [acrp_pkg::CAP_W-1:0]    cap_q;
  logic [acrp_pkg::EFFECT_W-1:0] eff0_q, eff1_q, eff2_q, eff3_q, eff_def_q;

  // Global tick state
  logic [TICK_W-1:0]             tick_count_q;
  logic [acrp_pkg::AMOUNT_W-1:0] amount_q;

  // Clearing pass counter
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // Captured command
  logic [acrp_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [IW-1:0]                 idx_q, idx_d;
  logic [acrp_pkg::ACTION_W-1:0] act_q, act_d;
  logic                          force_q, force_d;

  // Datapath registers
  logic signed [BAL_W-1:0]          bal_q, bal_d;
  logic [TICK_W-1:0]                elapsed_q, elapsed_d;
  logic [acrp_pkg::PROD_W-1:0]      prod_q, prod_d;
  logic signed [ALU_W-1:0]          acc_q, acc_d;
  logic signed [BAL_W-1:0]          prev_q, prev_d;
  logic signed [BAL_W-1:0]          next_q, next_d;

  // Result registers
  logic                    res_valid_q, res_valid_d;
  logic                    ok_q, ok_d;
  logic signed [BAL_W-1:0] res_bal_q, res_bal_d;

  // Tick update
  logic tick_en;

  // Table port
  logic              tbl_we;
  logic [AW-1:0]     tbl_addr;
  logic [WORD_W-1:0] tbl_wdata;
  logic [WORD_W-1:0] tbl_rdata;

  // Shared adder
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic                    alu_sub;

  logic signed [ALU_W-1:0]          cap_ext;
  logic [acrp_pkg::EFFECT_W-1:0]    eff_sel;
  logic signed [BAL_W-1:0]          eff_val;
  logic                             sum_fits;
  logic                             commit_ok;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != acrp_pkg::ST_IDLE);

  assign cap_ext = ALU_W'(cap_q);
  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  // Sum is representable in 32 bits when all bits above bit 30 agree
  assign sum_fits = (&alu_sum[ALU_W-1:BAL_W-1]) | ~(|alu_sum[ALU_W-1:BAL_W-1]);

  // Select the effect register for the held action
  always_comb begin
    case (act_q)
      acrp_pkg::ACT_0: eff_sel = eff0_q;
      acrp_pkg::ACT_1: eff_sel = eff1_q;
      acrp_pkg::ACT_2: eff_sel = eff2_q;
      acrp_pkg::ACT_3: eff_sel = eff3_q;
      default:         eff_sel = eff_def_q;
    endcase
  end
  assign eff_val = BAL_W'($signed(eff_sel[15:0]));

  assign commit_ok = (cmd_q == acrp_pkg::CMD_PERFORM) && ((next_q >= 0) || force_q);

  acrp_table #(
    .DEPTH (NUM_ACCOUNTS),
    .WIDTH (WORD_W),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .addr_i  (tbl_addr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  // Sequencer: next state, shared adder operands, table port, result
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    act_d       = act_q;
    force_d     = force_q;
    bal_d       = bal_q;
    elapsed_d   = elapsed_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    next_d      = next_q;
    res_valid_d = 1'b0;
    ok_d        = ok_q;
    res_bal_d   = res_bal_q;
    tick_en     = 1'b0;
    tbl_we      = 1'b0;
    tbl_addr    = idx_q[AW-1:0];
    tbl_wdata   = {tick_count_q, bal_q};
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    unique case (state_q)
      acrp_pkg::ST_CLEAR: begin
        // Sweep the table with the reset balance and a zero timestamp
        tbl_we    = 1'b1;
        tbl_addr  = clr_cnt_q;
        tbl_wdata = {{TICK_W{1'b0}}, acrp_pkg::INIT_BALANCE};
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_ENTRY) begin
          state_d = acrp_pkg::ST_IDLE;
        end
      end

      acrp_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d   = command_i;
          idx_d   = IW'(account_i);
          act_d   = action_i;
          force_d = force_req_i;
          if (command_i == acrp_pkg::CMD_TICK) begin
            tick_en     = 1'b1;
            res_valid_d = 1'b1;
            ok_d        = 1'b1;
            res_bal_d   = '0;
          end else if (command_i == acrp_pkg::CMD_PERFORM ||
                       command_i == acrp_pkg::CMD_CHECK) begin
            state_d = acrp_pkg::ST_REDUCE;
          end else begin
            // Unused command: report a rejection, change nothing
            res_valid_d = 1'b1;
            ok_d        = 1'b0;
            res_bal_d   = '0;
          end
        end
      end

      acrp_pkg::ST_REDUCE: begin
        // Subtract the table depth until the index falls inside the table
        alu_a   = ALU_W'(idx_q);
        alu_b   = ALU_W'(NUM_ACCOUNTS);
        alu_sub = 1'b1;
        if (alu_sum[ALU_W-1]) begin
          state_d = acrp_pkg::ST_READ;
        end else begin
          idx_d = alu_sum[IW-1:0];
        end
      end

      acrp_pkg::ST_READ: begin
        state_d = acrp_pkg::ST_ELAPSED;
      end

      acrp_pkg::ST_ELAPSED: begin
        // Elapsed ticks modulo 2^32
        alu_a     = ALU_W'(tick_count_q);
        alu_b     = ALU_W'(tbl_rdata[WORD_W-1:BAL_W]);
        alu_sub   = 1'b1;
        elapsed_d = alu_sum[TICK_W-1:0];
        bal_d     = $signed(tbl_rdata[BAL_W-1:0]);
        state_d   = acrp_pkg::ST_MUL;
      end

      acrp_pkg::ST_MUL: begin
        prod_d  = acrp_pkg::PROD_W'(elapsed_q) * acrp_pkg::PROD_W'(amount_q);
        state_d = acrp_pkg::ST_REFILL;
      end

      acrp_pkg::ST_REFILL: begin
        alu_a   = ALU_W'(bal_q);
        alu_b   = ALU_W'(prod_q);
        acc_d   = alu_sum;
        state_d = acrp_pkg::ST_CAP;
      end

      acrp_pkg::ST_CAP: begin
        // Clamp to the cap even with no ticks elapsed
        if (acc_q > cap_ext) begin
          prev_d = BAL_W'(cap_q);
        end else begin
          prev_d = acc_q[BAL_W-1:0];
        end
        state_d = acrp_pkg::ST_EFFECT;
      end

      acrp_pkg::ST_EFFECT: begin
        alu_a = ALU_W'(prev_q);
        alu_b = ALU_W'(eff_val);
        case (eff_sel[17:16])
          acrp_pkg::MODE_ADD: begin
            if (sum_fits) begin
              next_d = alu_sum[BAL_W-1:0];
            end else if (alu_sum[ALU_W-1]) begin
              next_d = BAL_MIN;
            end else begin
              next_d = BAL_MAX;
            end
          end
          acrp_pkg::MODE_SET: next_d = eff_val;
          default:            next_d = prev_q;
        endcase
        state_d = acrp_pkg::ST_COMMIT;
      end

      acrp_pkg::ST_COMMIT: begin
        // Store the refill always; store the effect only for an allowed perform
        tbl_we      = 1'b1;
        tbl_wdata   = {tick_count_q, (commit_ok ? next_q : prev_q)};
        res_valid_d = 1'b1;
        if (cmd_q == acrp_pkg::CMD_PERFORM) begin
          ok_d      = commit_ok;
          res_bal_d = commit_ok ? next_q : prev_q;
        end else begin
          ok_d      = (next_q >= 0);
          res_bal_d = prev_q;
        end
        state_d = acrp_pkg::ST_IDLE;
      end

      default: begin
        state_d = acrp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, tick state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acrp_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
      tick_count_q <= '0;
      amount_q     <= '0;
      cap_q        <= acrp_pkg::INIT_CAP;
      eff0_q       <= '0;
      eff1_q       <= '0;
      eff2_q       <= '0;
      eff3_q       <= '0;
      eff_def_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
      if (tick_en) begin
        tick_count_q <= tick_count_q + 1'b1;
        amount_q     <= tick_amount_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          acrp_pkg::REG_CAP:     cap_q     <= cfg_data_i;
          acrp_pkg::REG_EFFECT0: eff0_q    <= cfg_data_i[acrp_pkg::EFFECT_W-1:0];
          acrp_pkg::REG_EFFECT1: eff1_q    <= cfg_data_i[acrp_pkg::EFFECT_W-1:0];
          acrp_pkg::REG_EFFECT2: eff2_q    <= cfg_data_i[acrp_pkg::EFFECT_W-1:0];
          acrp_pkg::REG_EFFECT3: eff3_q    <= cfg_data_i[acrp_pkg::EFFECT_W-1:0];
          acrp_pkg::REG_DEFAULT: eff_def_q <= cfg_data_i[acrp_pkg::EFFECT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    act_q     <= act_d;
    force_q   <= force_d;
    bal_q     <= bal_d;
    elapsed_q <= elapsed_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    prev_q    <= prev_d;
    next_q    <= next_d;
    ok_q      <= ok_d;
    res_bal_q <= res_bal_d;
  end

  assign result_valid_o = res_valid_q;
  assign ok_o           = ok_q;
  assign balance_o      = res_bal_q;

endmodule

`default_nettype wire

/* verif/account_credit_refill_policer_checker.sv */
// Checker for the credit policer: predicts each command's result and compares it.
`timescale 1ns / 1ps

module account_credit_refill_policer_checker
  import acrp_pkg::*;
#(
  parameter int unsigned NUM_ACCOUNTS = NUM_ACCOUNTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_i,
  input  wire logic [CMD_W-1:0]            command_i,
  input  wire logic [AMOUNT_W-1:0]         tick_amount_i,
  input  wire logic [ACCOUNT_W-1:0]        account_i,
  input  wire logic [ACTION_W-1:0]         action_i,
  input  wire logic                        force_req_i,
  input  wire logic                        result_valid_i,
  input  wire logic                        ok_i,
  input  wire logic signed [BAL_W-1:0]     balance_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]        cfg_data_i,
  output int                               errors_o,
  output int                               outstanding_o
);

  typedef struct packed {
    logic                    ok;
    logic signed [BAL_W-1:0] balance;
  } outcome_t;

  outcome_t awaited_q[$];

  logic signed [BAL_W-1:0]  credit_tab [NUM_ACCOUNTS];
  logic [TICK_W-1:0]        stamp_tab  [NUM_ACCOUNTS];
  logic [TICK_W-1:0]        tick_cnt;
  logic [AMOUNT_W-1:0]      per_tick;
  logic [CAP_W-1:0]         cap_reg;
  logic [EFFECT_W-1:0]      effect_reg [5];

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
  end

  function automatic logic signed [BAL_W-1:0] clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
    return v[BAL_W-1:0];
  endfunction

  function automatic logic signed [BAL_W-1:0] effect_outcome(
    input logic signed [BAL_W-1:0] cur,
    input logic [EFFECT_W-1:0]     eff
  );
    longint delta;
    delta = longint'($signed(eff[15:0]));
    case (eff[17:16])
      MODE_ADD: return clamp32(longint'(cur) + delta);
      MODE_SET: return delta[BAL_W-1:0];
      default:  return cur;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors_o++;
  endtask

  // Work out the result of one accepted command and advance the model state.
  task automatic predict_command(
    input logic [CMD_W-1:0]     cmd,
    input logic [AMOUNT_W-1:0]  amt,
    input logic [ACCOUNT_W-1:0] acct,
    input logic [ACTION_W-1:0]  act,
    input logic                 frc
  );
    int unsigned             idx;
    int unsigned             sel;
    logic [TICK_W-1:0]       elapsed;
    logic [PROD_W-1:0]       gain;
    longint                  level;
    logic signed [BAL_W-1:0] prev;
    logic signed [BAL_W-1:0] next;
    outcome_t                res;
    res = '0;
    if (cmd == CMD_TICK) begin
      per_tick = amt;
      tick_cnt = tick_cnt + 1;
      res.ok   = 1'b1;
    end else if (cmd == CMD_PERFORM || cmd == CMD_CHECK) begin
      idx     = int'(acct) % NUM_ACCOUNTS;
      sel     = (act > ACT_3) ? 4 : int'(act);
      // lazy refill, stored for both perform and check
      elapsed = tick_cnt - stamp_tab[idx];
      gain    = elapsed * per_tick;
      level   = longint'(credit_tab[idx]) + longint'(gain);
      if (level > longint'(cap_reg)) level = longint'(cap_reg);
      prev    = level[BAL_W-1:0];
      credit_tab[idx] = prev;
      stamp_tab[idx]  = tick_cnt;
      next    = effect_outcome(prev, effect_reg[sel]);
      if (cmd == CMD_PERFORM) begin
        if (next >= 0 || frc) begin
          credit_tab[idx] = next;
          res.ok      = 1'b1;
          res.balance = next;
        end else begin
          res.balance = prev;
        end
      end else begin
        res.ok      = (next >= 0);
        res.balance = prev;
      end
    end
    awaited_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACCOUNTS; i++) begin
        credit_tab[i] = INIT_BALANCE;
        stamp_tab[i]  = '0;
      end
      tick_cnt = '0;
      per_tick = '0;
      cap_reg  = INIT_CAP;
      for (int i = 0; i < 5; i++) effect_reg[i] = '0;
      awaited_q.delete();
    end else begin
      // results belong to earlier items, so retire before predicting
      if (result_valid_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with no item pending (balance)", 0, balance_i);
        end else begin
          want = awaited_q.pop_front();
          if (ok_i !== want.ok) report_mismatch("ok", want.ok, ok_i);
          if (balance_i !== want.balance)
            report_mismatch("balance", $signed(want.balance), balance_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CAP:     cap_reg       = cfg_data_i[CAP_W-1:0];
          REG_EFFECT0: effect_reg[0] = cfg_data_i[EFFECT_W-1:0];
          REG_EFFECT1: effect_reg[1] = cfg_data_i[EFFECT_W-1:0];
          REG_EFFECT2: effect_reg[2] = cfg_data_i[EFFECT_W-1:0];
          REG_EFFECT3: effect_reg[3] = cfg_data_i[EFFECT_W-1:0];
          REG_DEFAULT: effect_reg[4] = cfg_data_i[EFFECT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && busy_i === 1'b0)
        predict_command(command_i, tick_amount_i, account_i, action_i, force_req_i);
    end
    outstanding_o = awaited_q.size();
  end

endmodule

/* verif/account_credit_refill_policer_test.sv */
// Testbench top for the credit policer: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module account_credit_refill_policer_test;
  import acrp_pkg::*;

  // Codes the package leaves unnamed but the ports allow
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [1:0]           MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam int STALL_LIMIT   = 5000;  // cycles with no handshake or result
  localparam int TAIL_CYCLES   = 24;    // idle tail after the final drain
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 200;
  // Back-to-back ticks at full amount, enough for a refill in the millions
  localparam int SAT_TICKS     = 64;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command = CMD_TICK;
  logic [AMOUNT_W-1:0]      tick_amount = '0;
  logic [ACCOUNT_W-1:0]     account = '0;
  logic [ACTION_W-1:0]      action = '0;
  logic                     force_req = 1'b0;
  logic                     result_valid;
  logic                     ok;
  logic signed [BAL_W-1:0]  balance;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_CAP;
  logic [CFG_DAT_W-1:0]     cfg_data = '0;

  int   errors;
  int   outstanding;
  int   idle_pct = 0;
  int   stall_cycles = 0;
  logic item_taken = 1'b0;
  logic cfg_taken = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  account_credit_refill_policer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command),
    .tick_amount_i  (tick_amount),
    .account_i      (account),
    .action_i       (action),
    .force_req_i    (force_req),
    .result_valid_o (result_valid),
    .ok_o           (ok),
    .balance_o      (balance),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  account_credit_refill_policer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command),
    .tick_amount_i  (tick_amount),
    .account_i      (account),
    .action_i       (action),
    .force_req_i    (force_req),
    .result_valid_i (result_valid),
    .ok_i           (ok),
    .balance_i      (balance),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .outstanding_o  (outstanding)
  );

  // Latch the handshakes at the rising edge; the driver looks at them on the falling one.
  always @(posedge clk_i) begin
    item_taken <= start && busy === 1'b0;
    cfg_taken  <= cfg_valid && cfg_ready === 1'b1;
  end

  // Watchdog: any handshake or result clears the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || result_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item, at times with a random idle gap ahead of it, and hold it until taken.
  task automatic send_item(
    input logic [CMD_W-1:0]     cmd,
    input logic [AMOUNT_W-1:0]  amt,
    input logic [ACCOUNT_W-1:0] acct,
    input logic [ACTION_W-1:0]  act,
    input logic                 frc
  );
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start       = 1'b1;
    command     = cmd;
    tick_amount = amt;
    account     = acct;
    action      = act;
    force_req   = frc;
    do @(negedge clk_i); while (!item_taken);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  // Hold off the sender until every expected result is back and the block is idle.
  task automatic drain();
    start = 1'b0;
    do @(negedge clk_i); while (outstanding != 0 || busy !== 1'b0);
  endtask

  // Mostly add effects with small, mostly negative deltas so both verdicts show up;
  // junk in the unused upper data bits must be dropped.
  function automatic logic [CFG_DAT_W-1:0] random_effect();
    logic [1:0]  mode;
    logic [15:0] val;
    case ($urandom_range(0, 9))
      0:       mode = MODE_NONE;
      1:       mode = MODE_SET;
      2:       mode = MODE_SPARE;
      default: mode = MODE_ADD;
    endcase
    case ($urandom_range(0, 7))
      0:       val = 16'h7FFF;
      1:       val = 16'h8000;
      2:       val = 16'h0000;
      3:       val = 16'($urandom);
      default: val = 16'($urandom_range(0, 4500) - 3000);
    endcase
    return {13'($urandom), mode, val};
  endfunction

  task automatic configure(input int seg);
    logic [CFG_DAT_W-1:0] cap_val;
    case (seg)
      1:       cap_val = '0;
      2:       cap_val = '1;
      3:       cap_val = 31'($urandom);
      5:       cap_val = 31'($urandom_range(0, 200000));
      default: cap_val = 31'($urandom_range(0, 30000));
    endcase
    write_reg(REG_CAP, cap_val);
    write_reg(REG_EFFECT0, random_effect());
    write_reg(REG_EFFECT1, random_effect());
    write_reg(REG_EFFECT2, random_effect());
    write_reg(REG_EFFECT3, random_effect());
    write_reg(REG_DEFAULT, random_effect());
    // unmapped indexes must leave every register alone
    if (seg == 3) begin
      write_reg(REG_SPARE6, 31'($urandom));
      write_reg(REG_SPARE7, 31'($urandom));
    end
  endtask

  // Random command: a handful of hot accounts so back-to-back hits on one entry are common.
  task automatic random_item();
    logic [CMD_W-1:0]     cmd;
    logic [AMOUNT_W-1:0]  amt;
    logic [ACCOUNT_W-1:0] acct;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      cmd = CMD_TICK;
    else if (pick < 65) cmd = CMD_PERFORM;
    else if (pick < 95) cmd = CMD_CHECK;
    else                cmd = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 6)      acct = 8'($urandom_range(0, 3));
    else if (pick < 7) acct = 8'hFF;
    else               acct = 8'($urandom);
    case ($urandom_range(0, 7))
      0:       amt = '0;
      1:       amt = '1;
      2:       amt = 16'($urandom);
      default: amt = 16'($urandom_range(0, 500));
    endcase
    send_item(cmd, amt, acct, 3'($urandom), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: effects chosen to hit reject, force, set extremes, the spare
    // mode and the default register; upper data bits set on one write.
    write_reg(REG_CAP, '1);
    write_reg(REG_EFFECT0, {13'h0000, MODE_ADD, 16'h8AD0});    // -30000
    write_reg(REG_EFFECT1, {13'h0000, MODE_SET, 16'h7FFF});
    write_reg(REG_EFFECT2, {13'h0000, MODE_SET, 16'h8000});
    write_reg(REG_EFFECT3, {13'h1FFF, MODE_SPARE, 16'h1234});
    write_reg(REG_DEFAULT, {13'h0000, MODE_ADD, 16'h7FFF});
    drain();

    send_item(CMD_CHECK,   '0, 8'd0, ACT_0, 1'b0);   // would go negative
    send_item(CMD_PERFORM, '0, 8'd0, ACT_0, 1'b0);   // rejected, balance kept
    send_item(CMD_PERFORM, '0, 8'd0, ACT_0, 1'b1);   // forced below zero
    send_item(CMD_PERFORM, '0, 8'd0, ACT_1, 1'b0);   // set to +32767
    send_item(CMD_PERFORM, '0, 8'd1, ACT_2, 1'b1);   // set to -32768
    send_item(CMD_PERFORM, '0, 8'd1, ACT_3, 1'b0);   // spare mode, still negative
    send_item(CMD_CHECK,   '0, 8'd1, ACT_3, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd2, 3'd4, 1'b0);    // default register
    send_item(CMD_CHECK,   '0, 8'd2, 3'd7, 1'b0);
    send_item(CMD_PERFORM, '0, 8'hFF, 3'd6, 1'b1);
    send_item(CMD_UNUSED,  '1, 8'hFF, 3'd7, 1'b1);   // no effect, ok low
    send_item(CMD_TICK,    '1, '0, '0, 1'b0);
    send_item(CMD_TICK,    '0, '1, '1, 1'b1);
    send_item(CMD_PERFORM, '0, 8'd0, 3'd5, 1'b0);    // ticks elapsed at zero amount
    send_item(CMD_TICK,    '1, '0, '0, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd3, ACT_0, 1'b0);   // refill covers the debit
    send_item(CMD_CHECK,   '0, 8'hFF, ACT_1, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd3, 3'd4, 1'b0);    // same entry back to back
    send_item(CMD_PERFORM, '0, 8'd3, 3'd4, 1'b0);
    drain();

    // Drop the cap to zero: a balance above it falls on the next access.
    write_reg(REG_CAP, '0);
    send_item(CMD_CHECK,   '0, 8'd2, ACT_2, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd2, ACT_0, 1'b0);
    drain();

    // Large refill: let untouched accounts gather a big gain, then act on them.
    write_reg(REG_CAP, '1);
    for (int i = 0; i < SAT_TICKS; i++) send_item(CMD_TICK, '1, '0, '0, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd200, 3'd4, 1'b0);
    send_item(CMD_CHECK,   '0, 8'd201, ACT_1, 1'b0);
    send_item(CMD_PERFORM, '0, 8'd201, ACT_0, 1'b0);
    drain();

    // Random segments: sender idles 31%, then 67%, then not at all; fresh
    // settings at each segment boundary, and a full drain now and then.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < 2) ? 31 : (seg < 4) ? 67 : 0;
      drain();
      configure(seg);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        random_item();
        if (n % 100 == 99) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
